// ===== rtl/core/hab_pkg.sv =====
// ----------------------------------------------------------------------------
// hab_pkg
// Shared types, constants and the arctangent table for the heading block.
// ----------------------------------------------------------------------------
`default_nettype none

package hab_pkg;

    // normalized magnitude sits just below this bit
    localparam int NORM_TOP  = 40;
    // CORDIC datapath width: normalized value plus gain growth and sign
    localparam int CORDIC_W  = 44;
    // binary angle, 2^32 units per full turn
    localparam int ANGLE_W   = 32;
    localparam int HEADING_W = 16;
    localparam int TABLE_LEN = 24;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // normalized difference vector handed from front to back
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic                       half;
        logic                       same;
    } norm_item_t;

    // atan(2^-i) as a binary angle
    function automatic logic [ANGLE_W-1:0] atan_entry(input int idx);
        logic [ANGLE_W-1:0] a;
        unique case (idx)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hab_fifo.sv =====
// ----------------------------------------------------------------------------
// hab_fifo
// Small register queue with occupancy count. Caller never pushes when full.
// ----------------------------------------------------------------------------
`default_nettype none

module hab_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_pop;

    assign do_pop   = pop && (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hab_front.sv =====
// ----------------------------------------------------------------------------
// hab_front
// Forms the difference vector, flags coincident points, folds the south half
// onto x >= 0 and normalizes the larger magnitude. Three stages, no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hab_front #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] from_north,
    input  wire logic signed [COORD_BITS-1:0] from_east,
    input  wire logic signed [COORD_BITS-1:0] to_north,
    input  wire logic signed [COORD_BITS-1:0] to_east,
    output logic                              out_valid,
    output hab_pkg::norm_item_t               out_item
);

    import hab_pkg::*;

    localparam int DW = COORD_BITS + 2;

    // stage 0
    logic signed [DW-1:0]       dn;
    logic signed [DW-1:0]       de;
    logic signed [CORDIC_W-1:0] x0_reg, y0_reg;
    logic                       half0_reg, same0_reg, v0_reg;

    // stage 1
    logic [NORM_TOP-1:0]        big1;
    logic [NORM_TOP-1:0]        ay;
    logic [NORM_TOP-1:0]        b1_next;
    logic signed [CORDIC_W-1:0] x1_next, y1_next;
    logic [NORM_TOP-1:0]        b1_reg;
    logic signed [CORDIC_W-1:0] x1_reg, y1_reg;
    logic                       half1_reg, same1_reg, v1_reg;

    // stage 2
    logic [NORM_TOP-1:0]        b2;
    logic signed [CORDIC_W-1:0] x2_next, y2_next;
    norm_item_t                 item_reg;
    logic                       v2_reg;

    assign dn = DW'(to_north) - DW'(from_north);
    assign de = DW'(to_east) - DW'(from_east);

    always_ff @(posedge clk)
    begin
        if (dn < 0)
        begin
            x0_reg    <= CORDIC_W'(-dn);
            y0_reg    <= CORDIC_W'(-de);
            half0_reg <= 1'b1;
        end
        else
        begin
            x0_reg    <= CORDIC_W'(dn);
            y0_reg    <= CORDIC_W'(de);
            half0_reg <= 1'b0;
        end
        same0_reg <= (dn == 0) && (de == 0);
    end

    // coarse shifts by 32, 16 and 8
    always_comb
    begin
        ay      = NORM_TOP'(y0_reg < 0 ? -y0_reg : y0_reg);
        big1    = NORM_TOP'(x0_reg);
        if (ay > big1)
        begin
            big1 = ay;
        end
        b1_next = big1;
        x1_next = x0_reg;
        y1_next = y0_reg;
        if (b1_next[NORM_TOP-1 -: 32] == '0)
        begin
            b1_next = b1_next << 32;
            x1_next = x1_next <<< 32;
            y1_next = y1_next <<< 32;
        end
        if (b1_next[NORM_TOP-1 -: 16] == '0)
        begin
            b1_next = b1_next << 16;
            x1_next = x1_next <<< 16;
            y1_next = y1_next <<< 16;
        end
        if (b1_next[NORM_TOP-1 -: 8] == '0)
        begin
            b1_next = b1_next << 8;
            x1_next = x1_next <<< 8;
            y1_next = y1_next <<< 8;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg    <= b1_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        half1_reg <= half0_reg;
        same1_reg <= same0_reg;
    end

    // fine shifts by 4, 2 and 1
    always_comb
    begin
        b2      = b1_reg;
        x2_next = x1_reg;
        y2_next = y1_reg;
        if (b2[NORM_TOP-1 -: 4] == '0)
        begin
            b2      = b2 << 4;
            x2_next = x2_next <<< 4;
            y2_next = y2_next <<< 4;
        end
        if (b2[NORM_TOP-1 -: 2] == '0)
        begin
            b2      = b2 << 2;
            x2_next = x2_next <<< 2;
            y2_next = y2_next <<< 2;
        end
        if (!b2[NORM_TOP-1])
        begin
            x2_next = x2_next <<< 1;
            y2_next = y2_next <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg.x    <= x2_next;
        item_reg.y    <= y2_next;
        item_reg.half <= half1_reg;
        item_reg.same <= same1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hab_back.sv =====
// ----------------------------------------------------------------------------
// hab_back
// Pipelined CORDIC vectoring, one stage per iteration, then scaling of the
// binary angle to degrees with round-to-nearest and wrap of a full turn.
// ----------------------------------------------------------------------------
`default_nettype none

module hab_back #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire hab_pkg::norm_item_t  in_item,
    output logic                      out_valid,
    output logic [hab_pkg::HEADING_W-1:0] out_heading,
    output logic                      out_same
);

    import hab_pkg::*;

    // 360 needs 9 bits
    localparam int FULL_W = ANGLE_FRAC_BITS + 9;
    localparam int PROD_W = ANGLE_W + FULL_W;
    localparam logic [FULL_W-1:0] FULL_TURN = FULL_W'(360 << ANGLE_FRAC_BITS);

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS];
    logic [ANGLE_W-1:0]         z_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0]    same_reg;
    logic [CORDIC_STEPS-1:0]    valid_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] xi, yi, xs, ys, x_next, y_next;
        logic [ANGLE_W-1:0]         zi, z_next;
        logic                       si, vi;

        if (i == 0)
        begin : g_first
            assign xi = in_item.x;
            assign yi = in_item.y;
            assign zi = in_item.half ? HALF_TURN : '0;
            assign si = in_item.same;
            assign vi = in_valid;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign si = same_reg[i-1];
            assign vi = valid_reg[i-1];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;

        always_comb
        begin
            if (yi >= 0)
            begin
                x_next = xi + ys;
                y_next = yi - xs;
                z_next = zi + atan_entry(i);
            end
            else
            begin
                x_next = xi - ys;
                y_next = yi + xs;
                z_next = zi - atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]    <= x_next;
            y_reg[i]    <= y_next;
            z_reg[i]    <= z_next;
            same_reg[i] <= si;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= vi;
            end
        end
    end

    // scale stage
    logic [PROD_W-1:0] prod_reg;
    logic              msame_reg, mvalid_reg;

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(z_reg[CORDIC_STEPS-1]) * PROD_W'(FULL_TURN);
        msame_reg <= same_reg[CORDIC_STEPS-1];
    end

    // round stage
    logic [PROD_W:0]           rsum;
    logic [FULL_W:0]           h_round;
    logic [FULL_W:0]           h_wrap;
    logic [HEADING_W-1:0]      heading_reg;
    logic                      same_out_reg, valid_out_reg;

    assign rsum    = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(HALF_TURN);
    assign h_round = rsum[PROD_W:ANGLE_W];
    assign h_wrap  = (h_round >= (FULL_W+1)'(FULL_TURN)) ? '0 : h_round;

    always_ff @(posedge clk)
    begin
        heading_reg  <= msame_reg ? '0 : HEADING_W'(h_wrap);
        same_out_reg <= msame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg    <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            mvalid_reg    <= valid_reg[CORDIC_STEPS-1];
            valid_out_reg <= mvalid_reg;
        end
    end

    assign out_valid   = valid_out_reg;
    assign out_heading = heading_reg;
    assign out_same    = same_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/heading_angle_between_points.sv =====
// ----------------------------------------------------------------------------
// heading_angle_between_points
// Heading from one planar point to another, 0 to under 360 degrees, north
// toward east, by normalized CORDIC vectoring.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  input     | push / full      | from_north, from_east, to_north, to_east
//  result    | pop / empty      | heading, same_point
//
//  One item per cycle sustained while results are popped as they arrive. An
//  accepted item passes 3 front stages, the mid queue, CORDIC_STEPS CORDIC
//  stages and 2 back stages into the output queue. Reset clears pointers,
//  counters and valid bits only. full rises when the mid queue plus front
//  stages hold MQ_DEPTH items; the back issues from the mid queue only while
//  the output queue has a slot for every back pipeline item and the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_angle_between_points #(
    parameter int CORDIC_STEPS    = 16,
    parameter int COORD_BITS      = 24,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] from_north,
    input  wire logic signed [COORD_BITS-1:0] from_east,
    input  wire logic signed [COORD_BITS-1:0] to_north,
    input  wire logic signed [COORD_BITS-1:0] to_east,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [hab_pkg::HEADING_W-1:0]     heading,
    output logic                              same_point
);

    import hab_pkg::*;

    localparam int MQ_DEPTH = 8;
    localparam int MQ_CW    = $clog2(MQ_DEPTH+1);
    localparam int BACK_LAT = CORDIC_STEPS + 2;
    localparam int OQ_DEPTH = 1 << $clog2(BACK_LAT + 2);
    localparam int OQ_CW    = $clog2(OQ_DEPTH+1);
    localparam int OQ_W     = HEADING_W + 1;

    logic               in_xfer;
    logic               front_valid;
    norm_item_t         front_item;
    logic [MQ_CW-1:0]   front_cnt_reg;
    logic [MQ_CW-1:0]   mq_count;
    logic [$bits(norm_item_t)-1:0] mq_data;
    logic               issue;

    logic               back_valid;
    logic [HEADING_W-1:0] back_heading;
    logic               back_same;
    logic [OQ_CW-1:0]   back_cnt_reg;
    logic [OQ_CW-1:0]   oq_count;
    logic [OQ_W-1:0]    oq_data;

    // input credit: mid queue slots not yet claimed by front stages
    assign full    = (MQ_CW+1)'(mq_count) + (MQ_CW+1)'(front_cnt_reg)
                     >= (MQ_CW+1)'(MQ_DEPTH);
    assign in_xfer = push && !full;

    hab_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_xfer),
        .from_north (from_north),
        .from_east  (from_east),
        .to_north   (to_north),
        .to_east    (to_east),
        .out_valid  (front_valid),
        .out_item   (front_item)
    );

    hab_fifo #(
        .WIDTH (($bits(norm_item_t))),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_item),
        .pop       (issue),
        .pop_data  (mq_data),
        .count     (mq_count)
    );

    assign issue = (mq_count != '0) &&
                   ((OQ_CW+1)'(oq_count) + (OQ_CW+1)'(back_cnt_reg)
                    < (OQ_CW+1)'(OQ_DEPTH));

    hab_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (issue),
        .in_item     (norm_item_t'(mq_data)),
        .out_valid   (back_valid),
        .out_heading (back_heading),
        .out_same    (back_same)
    );

    hab_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (back_valid),
        .push_data ({back_same, back_heading}),
        .pop       (pop),
        .pop_data  (oq_data),
        .count     (oq_count)
    );

    assign empty      = (oq_count == '0);
    assign heading    = oq_data[HEADING_W-1:0];
    assign same_point = oq_data[HEADING_W];

    // items in flight through the front and back pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
        end
        else
        begin
            if (in_xfer && !front_valid)
            begin
                front_cnt_reg <= front_cnt_reg + 1'b1;
            end
            else if (!in_xfer && front_valid)
            begin
                front_cnt_reg <= front_cnt_reg - 1'b1;
            end
            if (issue && !back_valid)
            begin
                back_cnt_reg <= back_cnt_reg + 1'b1;
            end
            else if (!issue && back_valid)
            begin
                back_cnt_reg <= back_cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
